### rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] dev_addr;
        logic [7:0] reg_index;
        logic [7:0] write_value;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } t_res;

endpackage

`default_nettype wire

### rtl/i2cm_if.sv
`default_nettype none

interface i2cm_req_if;
    logic            valid;
    logic            ready;
    i2cm_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
    logic            valid;
    logic            ready;
    i2cm_pkg::t_res  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/i2cm_seq.sv
`default_nettype none

module i2cm_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire i2cm_pkg::t_req i_req,
    output i2cm_pkg::t_res      o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_WADDR, PH_WREG, PH_WDATA,
        PH_RSTART, PH_RADDR, PH_READ, PH_STOP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_sub, n_sub;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic [6:0]  r_addr, n_addr;
    logic [7:0]  r_reg, n_reg;
    logic [7:0]  r_data, n_data;
    logic        r_rd, n_rd;
    logic [7:0]  r_rx, n_rx;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_drv, n_drv;
    logic        n_drv_out;
    logic        n_busy;
    logic        n_done;
    logic        n_enter;
    t_phase      n_target;

    function automatic logic [7:0] load_shift(input t_phase ph, input logic [6:0] addr,
                                              input logic [7:0] rg, input logic [7:0] dat);
        logic [7:0] v;
        case (ph)
            PH_WADDR: v = {addr, 1'b0};
            PH_WREG:  v = rg;
            PH_WDATA: v = dat;
            PH_RADDR: v = {addr, 1'b1};
            default:  v = 8'd0;
        endcase
        return v;
    endfunction

    always_comb begin
        n_phase   = r_phase;
        n_sub     = r_sub;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_addr    = r_addr;
        n_reg     = r_reg;
        n_data    = r_data;
        n_rd      = r_rd;
        n_rx      = r_rx;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        n_drv_out = r_drv;
        n_busy    = 1'b0;
        n_done    = 1'b0;
        n_enter   = 1'b0;
        n_target  = PH_IDLE;

        if (r_phase != PH_IDLE) begin
            n_busy = 1'b1;
            if (i_req.operation == i2cm_pkg::OP_TICK) begin
                case (r_phase)
                    PH_START, PH_RSTART: begin
                        case (r_sub)
                            2'd0: begin
                                n_sda = 1'b1;
                                n_scl = 1'b1;
                                n_sub = 2'd1;
                            end
                            2'd1: begin
                                n_sda = 1'b0;
                                n_sub = 2'd2;
                            end
                            default: begin
                                n_scl    = 1'b0;
                                n_enter  = 1'b1;
                                n_target = (r_phase == PH_START) ? PH_WADDR : PH_RADDR;
                            end
                        endcase
                    end
                    PH_WADDR, PH_WREG, PH_WDATA, PH_RADDR: begin
                        if (r_bits < i2cm_pkg::BITS_PER_BYTE) begin
                            case (r_sub)
                                2'd0: begin
                                    n_sda = r_shift[7];
                                    n_sub = 2'd1;
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                    n_sub = 2'd2;
                                end
                                default: begin
                                    n_scl   = 1'b0;
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_bits  = r_bits + 4'd1;
                                    n_sub   = 2'd0;
                                end
                            endcase
                        end else begin
                            case (r_sub)
                                2'd0: begin
                                    n_drv     = 1'b0;
                                    n_drv_out = 1'b0;
                                    n_sub     = 2'd1;
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                    n_sub = 2'd2;
                                end
                                default: begin
                                    n_scl   = 1'b0;
                                    n_drv   = 1'b1;
                                    n_enter = 1'b1;
                                    case (r_phase)
                                        PH_WADDR: n_target = PH_WREG;
                                        PH_WREG:  n_target = r_rd ? PH_RSTART : PH_WDATA;
                                        PH_WDATA: n_target = PH_STOP;
                                        default:  n_target = PH_READ;
                                    endcase
                                end
                            endcase
                        end
                    end
                    PH_READ: begin
                        if (r_bits < i2cm_pkg::BITS_PER_BYTE) begin
                            case (r_sub)
                                2'd0: begin
                                    n_drv     = 1'b0;
                                    n_drv_out = 1'b0;
                                    n_scl     = 1'b1;
                                    n_shift   = {r_shift[6:0], i_req.sda_in};
                                    n_sub     = 2'd1;
                                end
                                default: begin
                                    n_scl  = 1'b0;
                                    n_bits = r_bits + 4'd1;
                                    n_sub  = 2'd0;
                                    if (r_bits == i2cm_pkg::BITS_PER_BYTE - 4'd1) begin
                                        n_rx = r_shift;
                                    end
                                end
                            endcase
                        end else begin
                            case (r_sub)
                                2'd0: begin
                                    n_drv     = 1'b1;
                                    n_drv_out = 1'b1;
                                    n_sda     = 1'b1;
                                    n_sub     = 2'd1;
                                end
                                2'd1: begin
                                    n_scl = 1'b1;
                                    n_sub = 2'd2;
                                end
                                default: begin
                                    n_scl    = 1'b0;
                                    n_enter  = 1'b1;
                                    n_target = PH_STOP;
                                end
                            endcase
                        end
                    end
                    PH_STOP: begin
                        case (r_sub)
                            2'd0: begin
                                n_sda = 1'b0;
                                n_sub = 2'd1;
                            end
                            2'd1: begin
                                n_scl = 1'b1;
                                n_sub = 2'd2;
                            end
                            default: begin
                                n_sda    = 1'b1;
                                n_done   = 1'b1;
                                n_enter  = 1'b1;
                                n_target = PH_IDLE;
                            end
                        endcase
                    end
                    default: begin
                        n_enter  = 1'b1;
                        n_target = PH_IDLE;
                    end
                endcase
            end
        end else if (i_req.operation == i2cm_pkg::OP_WRITE ||
                     i_req.operation == i2cm_pkg::OP_READ) begin
            n_addr = i_req.dev_addr;
            n_reg  = i_req.reg_index;
            if (i_req.operation == i2cm_pkg::OP_WRITE) begin
                n_data = i_req.write_value;
            end
            n_rd     = (i_req.operation == i2cm_pkg::OP_READ);
            n_busy   = 1'b1;
            n_enter  = 1'b1;
            n_target = PH_START;
        end

        if (n_enter) begin
            n_phase = n_target;
            n_sub   = 2'd0;
            n_bits  = 4'd0;
            n_shift = load_shift(n_target, n_addr, n_reg, n_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sub   <= 2'd0;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_addr  <= 7'd0;
            r_reg   <= 8'd0;
            r_data  <= 8'd0;
            r_rd    <= 1'b0;
            r_rx    <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b1;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_addr  <= n_addr;
            r_reg   <= n_reg;
            r_data  <= n_data;
            r_rd    <= n_rd;
            r_rx    <= n_rx;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
        end
    end

    always_comb begin
        o_res.scl        = n_scl;
        o_res.sda_out    = n_sda;
        o_res.sda_drive  = n_drv_out;
        o_res.busy_res   = n_busy;
        o_res.done_res   = n_done;
        o_res.read_value = n_rx;
    end

endmodule

`default_nettype wire

### rtl/i2cm_outbuf.sv
`default_nettype none

module i2cm_outbuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire i2cm_pkg::t_res i_res,
    output logic                o_space,
    i2cm_res_if.source          o_out
);

    logic           r_main_valid;
    logic           r_skid_valid;
    i2cm_pkg::t_res r_main;
    i2cm_pkg::t_res r_skid;
    logic           w_pop;

    assign w_pop   = r_main_valid && o_out.ready;
    assign o_space = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop || !r_main_valid) begin
                if (r_skid_valid) begin
                    r_main       <= r_skid;
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main       <= i_res;
                    r_main_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out.valid = r_main_valid;
    assign o_out.data  = r_main;

endmodule

`default_nettype wire

### rtl/i2c_bitbang_register_master.sv
// Channel   Dir  Payload                                           Handshake
// i_req     in   operation dev_addr reg_index write_value sda_in   valid/ready
// o_res     out  scl sda_out sda_drive busy_res done_res read_value valid/ready
//
// One transaction in, one result out; one per clock while o_res accepts results.
// Path: input register, then sequencer step into the result buffer.
// The two-entry result buffer keeps input flowing after o_res stalls until it is full.
// Reset (synchronous, active low) leaves the bus idle: SCL and SDA high, SDA driven.
`default_nettype none

module i2c_bitbang_register_master (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    i2cm_req_if.sink    i_req,
    i2cm_res_if.source  o_res
);

    logic           r_in_valid;
    i2cm_pkg::t_req r_in;
    logic           w_space;
    logic           w_adv;
    i2cm_pkg::t_res w_res;

    assign w_adv       = r_in_valid && w_space;
    assign i_req.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    i2cm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv),
        .i_res   (w_res),
        .o_space (w_space),
        .o_out   (o_res)
    );

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_space |=> r_in_valid)
        else $error("held transaction dropped while result buffer full");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |-> !r_in_valid || w_adv)
        else $error("input register overwritten before it advanced");

    a_done_bus_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_res.done_res |-> w_res.busy_res && w_res.scl && w_res.sda_out)
        else $error("STOP did not end with both lines high");

    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !w_res.busy_res |-> w_res.scl && w_res.sda_out && w_res.sda_drive)
        else $error("idle bus not released high");

endmodule

`default_nettype wire

### tb/sv/tb_i2c_bitbang_register_master.sv
module tb_i2c_bitbang_register_master;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int ITEM_TARGET     = 1250;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic [3:0] {
        BUS_IDLE, BUS_START, BUS_ADDR_W, BUS_REG, BUS_DATA,
        BUS_RESTART, BUS_ADDR_R, BUS_READ, BUS_STOP
    } t_bus_state;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} t_sink_mode;

    logic clk;
    logic rst_n;

    i2cm_req_if req_ch();
    i2cm_res_if res_ch();

    i2c_bitbang_register_master uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_bus_state bus_phase;
    logic [1:0] step_no;
    logic [3:0] bits_done;
    logic [7:0] shifter;
    logic [6:0] lat_addr;
    logic [7:0] lat_reg;
    logic [7:0] lat_data;
    logic       is_read;
    logic [7:0] rx_byte;
    logic       scl_q;
    logic       sda_q;
    logic       drive_q;

    i2cm_pkg::t_res pending_levels[$];
    int   error_count = 0;
    int   items_sent  = 0;
    int   burst_left  = 0;
    bit   sender_calm = 0;
    int   idle_cycles = 0;
    t_sink_mode sink_mode = SINK_OPEN;
    int   sink_left   = 0;
    int   sink_tick   = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void enter_state(input t_bus_state nxt);
        bus_phase = nxt;
        step_no   = 2'd0;
        bits_done = 4'd0;
        case (nxt)
            BUS_ADDR_W: shifter = {lat_addr, 1'b0};
            BUS_REG:    shifter = lat_reg;
            BUS_DATA:   shifter = lat_data;
            BUS_ADDR_R: shifter = {lat_addr, 1'b1};
            default:    shifter = 8'h00;
        endcase
    endfunction

    function automatic void reset_bus_model();
        bus_phase = BUS_IDLE;
        step_no   = 2'd0;
        bits_done = 4'd0;
        shifter   = 8'h00;
        lat_addr  = 7'h00;
        lat_reg   = 8'h00;
        lat_data  = 8'h00;
        is_read   = 1'b0;
        rx_byte   = 8'h00;
        scl_q     = 1'b1;
        sda_q     = 1'b1;
        drive_q   = 1'b1;
    endfunction

    function automatic i2cm_pkg::t_res predict_bus_levels(input i2cm_pkg::t_req rq);
        i2cm_pkg::t_res lv;
        logic busy;
        logic finish;
        logic restore;
        busy    = 1'b0;
        finish  = 1'b0;
        restore = 1'b0;
        if (bus_phase != BUS_IDLE) begin
            busy = 1'b1;
            if (rq.operation == i2cm_pkg::OP_TICK) begin
                case (bus_phase)
                    BUS_START, BUS_RESTART: begin
                        if (step_no == 2'd0) begin
                            sda_q = 1'b1;
                            scl_q = 1'b1;
                            step_no = 2'd1;
                        end else if (step_no == 2'd1) begin
                            sda_q = 1'b0;
                            step_no = 2'd2;
                        end else begin
                            scl_q = 1'b0;
                            enter_state(bus_phase == BUS_START ? BUS_ADDR_W : BUS_ADDR_R);
                        end
                    end
                    BUS_ADDR_W, BUS_REG, BUS_DATA, BUS_ADDR_R: begin
                        if (bits_done < i2cm_pkg::BITS_PER_BYTE) begin
                            if (step_no == 2'd0) begin
                                sda_q = shifter[7];
                                step_no = 2'd1;
                            end else if (step_no == 2'd1) begin
                                scl_q = 1'b1;
                                step_no = 2'd2;
                            end else begin
                                scl_q = 1'b0;
                                shifter = {shifter[6:0], 1'b0};
                                bits_done = bits_done + 4'd1;
                                step_no = 2'd0;
                            end
                        end else begin
                            if (step_no == 2'd0) begin
                                drive_q = 1'b0;
                                step_no = 2'd1;
                            end else if (step_no == 2'd1) begin
                                scl_q = 1'b1;
                                step_no = 2'd2;
                            end else begin
                                scl_q = 1'b0;
                                restore = 1'b1;
                                case (bus_phase)
                                    BUS_ADDR_W: enter_state(BUS_REG);
                                    BUS_REG:    enter_state(is_read ? BUS_RESTART : BUS_DATA);
                                    BUS_DATA:   enter_state(BUS_STOP);
                                    default:    enter_state(BUS_READ);
                                endcase
                            end
                        end
                    end
                    BUS_READ: begin
                        if (bits_done < i2cm_pkg::BITS_PER_BYTE) begin
                            if (step_no == 2'd0) begin
                                drive_q = 1'b0;
                                scl_q = 1'b1;
                                shifter = {shifter[6:0], rq.sda_in};
                                step_no = 2'd1;
                            end else begin
                                scl_q = 1'b0;
                                bits_done = bits_done + 4'd1;
                                step_no = 2'd0;
                                if (bits_done == i2cm_pkg::BITS_PER_BYTE) rx_byte = shifter;
                            end
                        end else begin
                            if (step_no == 2'd0) begin
                                drive_q = 1'b1;
                                sda_q = 1'b1;
                                step_no = 2'd1;
                            end else if (step_no == 2'd1) begin
                                scl_q = 1'b1;
                                step_no = 2'd2;
                            end else begin
                                scl_q = 1'b0;
                                enter_state(BUS_STOP);
                            end
                        end
                    end
                    BUS_STOP: begin
                        if (step_no == 2'd0) begin
                            sda_q = 1'b0;
                            step_no = 2'd1;
                        end else if (step_no == 2'd1) begin
                            scl_q = 1'b1;
                            step_no = 2'd2;
                        end else begin
                            sda_q = 1'b1;
                            finish = 1'b1;
                            enter_state(BUS_IDLE);
                        end
                    end
                    default: enter_state(BUS_IDLE);
                endcase
            end
        end else if (rq.operation == i2cm_pkg::OP_WRITE ||
                     rq.operation == i2cm_pkg::OP_READ) begin
            lat_addr = rq.dev_addr;
            lat_reg  = rq.reg_index;
            if (rq.operation == i2cm_pkg::OP_WRITE) lat_data = rq.write_value;
            is_read  = (rq.operation == i2cm_pkg::OP_READ);
            enter_state(BUS_START);
            busy = 1'b1;
        end
        lv.scl        = scl_q;
        lv.sda_out    = sda_q;
        lv.sda_drive  = drive_q;
        lv.busy_res   = busy;
        lv.done_res   = finish;
        lv.read_value = rx_byte;
        if (restore) drive_q = 1'b1;
        return lv;
    endfunction

    task automatic send_item(input i2cm_pkg::t_req item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = sender_calm ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge clk); while (!req_ch.ready);
        pending_levels.push_back(predict_bus_levels(item));
        items_sent++;
    endtask

    function automatic i2cm_pkg::t_req random_req(input logic [1:0] op);
        i2cm_pkg::t_req rq;
        rq.operation   = op;
        rq.dev_addr    = 7'($urandom);
        rq.reg_index   = 8'($urandom);
        rq.write_value = 8'($urandom);
        rq.sda_in      = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic logic [1:0] noise_op();
        case ($urandom_range(0, 2))
            0:       return i2cm_pkg::OP_WRITE;
            1:       return i2cm_pkg::OP_READ;
            default: return OP_NONE;
        endcase
    endfunction

    // tick until the bus goes idle; rx_pattern feeds the sampled read bits
    task automatic finish_transfer(input logic [7:0] rx_pattern, input int noise_pct);
        i2cm_pkg::t_req rq;
        while (bus_phase != BUS_IDLE) begin
            rq = random_req(i2cm_pkg::OP_TICK);
            if ($urandom_range(1, 100) <= noise_pct) rq.operation = noise_op();
            if (bus_phase == BUS_READ && step_no == 2'd0 &&
                bits_done < i2cm_pkg::BITS_PER_BYTE)
                rq.sda_in = rx_pattern[3'd7 - bits_done[2:0]];
            send_item(rq);
        end
    endtask

    task automatic begin_transfer(input logic [1:0] op, input logic [6:0] addr,
                                  input logic [7:0] regi, input logic [7:0] data);
        i2cm_pkg::t_req rq;
        rq = random_req(op);
        rq.dev_addr    = addr;
        rq.reg_index   = regi;
        rq.write_value = data;
        send_item(rq);
    endtask

    task automatic test_idle_noise();
        i2cm_pkg::t_req rq;
        rq = '{operation: i2cm_pkg::OP_TICK, dev_addr: 7'h00, reg_index: 8'h00,
               write_value: 8'h00, sda_in: 1'b0};
        send_item(rq);
        rq = '{operation: OP_NONE, dev_addr: 7'h7F, reg_index: 8'hFF,
               write_value: 8'hFF, sda_in: 1'b1};
        send_item(rq);
        rq.operation = i2cm_pkg::OP_TICK;
        send_item(rq);
    endtask

    task automatic test_write_extremes();
        begin_transfer(i2cm_pkg::OP_WRITE, 7'h7F, 8'h00, 8'hFF);
        finish_transfer(8'h00, 0);
        begin_transfer(i2cm_pkg::OP_WRITE, 7'h00, 8'hFF, 8'h00);
        finish_transfer(8'h00, 0);
    endtask

    task automatic test_read_extremes();
        begin_transfer(i2cm_pkg::OP_READ, 7'h00, 8'hFF, 8'h5A);
        finish_transfer(8'hFF, 0);
        begin_transfer(i2cm_pkg::OP_READ, 7'h7F, 8'h00, 8'hA5);
        finish_transfer(8'h00, 0);
        begin_transfer(i2cm_pkg::OP_READ, 7'h2A, 8'h55, 8'h00);
        finish_transfer(8'hA5, 0);
    endtask

    task automatic test_busy_requests();
        begin_transfer(i2cm_pkg::OP_WRITE, 7'h15, 8'h3C, 8'hC3);
        send_item(random_req(i2cm_pkg::OP_READ));
        send_item(random_req(i2cm_pkg::OP_WRITE));
        send_item(random_req(OP_NONE));
        finish_transfer(8'h00, 0);
    endtask

    task automatic test_random_traffic();
        int n;
        while (items_sent < ITEM_TARGET) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            n = $urandom_range(0, 3);
            repeat (n) send_item(random_req($urandom_range(0, 1) ?
                                            i2cm_pkg::OP_TICK : OP_NONE));
            send_item(random_req($urandom_range(0, 1) ?
                                 i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ));
            finish_transfer(8'($urandom), 4);
        end
        sender_calm = 1'b0;
    endtask

    task automatic report_error(input string what, input logic [7:0] want,
                                input logic [7:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    always @(posedge clk) begin : check_results
        i2cm_pkg::t_res want;
        i2cm_pkg::t_res got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (pending_levels.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: %p", $realtime, got);
            end else begin
                want = pending_levels.pop_front();
                if (got.scl !== want.scl)
                    report_error("scl", 8'(want.scl), 8'(got.scl));
                if (got.sda_out !== want.sda_out)
                    report_error("sda_out", 8'(want.sda_out), 8'(got.sda_out));
                if (got.sda_drive !== want.sda_drive)
                    report_error("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
                if (got.busy_res !== want.busy_res)
                    report_error("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                if (got.done_res !== want.done_res)
                    report_error("done_res", 8'(want.done_res), 8'(got.done_res));
                if (got.read_value !== want.read_value)
                    report_error("read_value", want.read_value, got.read_value);
            end
        end
    end

    always @(negedge clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(40, 300);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            SINK_OPEN:   res_ch.ready <= 1'b1;
            SINK_RANDOM: res_ch.ready <= ($urandom_range(0, 2) != 0);
            default:     res_ch.ready <= (sink_tick % 9) > 3;
        endcase
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_i2c_bitbang_register_master: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        reset_bus_model();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_noise();
        test_write_extremes();
        test_read_extremes();
        test_busy_requests();
        test_random_traffic();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("tb_i2c_bitbang_register_master: clean");
        end else begin
            $display("tb_i2c_bitbang_register_master: errors");
        end
        $finish;
    end
endmodule

### sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_if.sv
rtl/i2cm_seq.sv
rtl/i2cm_outbuf.sv
rtl/i2c_bitbang_register_master.sv
tb/sv/tb_i2c_bitbang_register_master.sv
